// ===== rtl/gsrs_pkg.sv =====
// Shared types and constants of the gradient stop ramp sampler.
package gsrs_pkg;

  localparam int STOP_DEPTH_DEF   = 256;
  localparam int RAMP_SAMPLES_DEF = 256;
  localparam int OFF_W            = 20;
  localparam int NOFF_W           = 17;
  localparam int COL_W            = 64;
  localparam int CH_W             = 16;
  localparam int ONE_Q16          = 65536;

  typedef enum logic [1:0] {
    FN_LOAD   = 2'd0,
    FN_CLEAR  = 2'd1,
    FN_SAMPLE = 2'd2,
    FN_NONE   = 2'd3
  } func_t;

  typedef struct packed {
    logic [1:0]         func;
    logic signed [19:0] stop_offset;
    logic [15:0]        stop_red;
    logic [15:0]        stop_green;
    logic [15:0]        stop_blue;
    logic [15:0]        stop_alpha;
    logic [7:0]         sample_index;
  } in_t;

  typedef struct packed {
    logic [15:0] out_red;
    logic [15:0] out_green;
    logic [15:0] out_blue;
    logic [15:0] out_alpha;
    logic [7:0]  loaded_count;
    logic        table_full;
  } out_t;

  typedef struct packed {
    logic signed [OFF_W-1:0] off;
    logic [COL_W-1:0]        col;
  } raw_ent_t;

  typedef struct packed {
    logic [NOFF_W-1:0] off;
    logic [COL_W-1:0]  col;
  } norm_ent_t;

  typedef enum logic [1:0] {
    MX_HEAD,
    MX_TAIL,
    MX_SAMPLE
  } mix_sel_t;

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_INS_RD,
    ST_INS_CMP,
    ST_RB_Z0,
    ST_RB_Z1,
    ST_SC_RD,
    ST_SC_CHK,
    ST_CP_SET,
    ST_CP_RD,
    ST_CP_WR,
    ST_ONE0,
    ST_ONE1,
    ST_CLIP_HEAD,
    ST_CLIP_TAIL,
    ST_PAD_HEAD,
    ST_PAD_TAIL,
    ST_SM_RD0,
    ST_SM_LD0,
    ST_SM_RD,
    ST_SM_CMP,
    ST_SM_DEN,
    ST_MIX_MUL,
    ST_MIX_LD,
    ST_MIX_DIV,
    ST_MIX_WB,
    ST_MIX_DONE,
    ST_FIN
  } state_t;

endpackage

// ===== rtl/gradient_stop_ramp_sampler_unit.sv =====
// Gradient stop ramp sampler: sorted stop table, renormalizer and sampler.
//
// One item is taken when start is high and busy is low; busy drops in the cycle
// its result is shown for one cycle on out_item with out_valid, so the next item
// can be taken at the edge that ends that cycle. The receiver cannot stall.
// Clear, dropped loads and unused codes go straight to the result state. A load
// walks the table from its end, one read and compare pair per larger stop moved
// up. A sample walks the normalized table one stop per read and compare pair and
// then runs one shared multiply and bit-serial divide unit over the four
// channels, or skips it when the segment has zero length. The first sample after
// a change also rebuilds the normalized table first: a black and a white stop for
// an empty table; otherwise a scan of the stops, a setup state, a copy of each
// surviving stop, then two flat stops for a single stop or the end checks and
// pads, with a mix run for each clipped end.
module gradient_stop_ramp_sampler_unit #(
  parameter int STOP_DEPTH   = gsrs_pkg::STOP_DEPTH_DEF,
  parameter int RAMP_SAMPLES = gsrs_pkg::RAMP_SAMPLES_DEF
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           start,
  output logic           busy,
  input  gsrs_pkg::in_t  in_item,
  output logic           out_valid,
  output gsrs_pkg::out_t out_item
);

  localparam int AW     = $clog2(STOP_DEPTH);
  localparam int LAST_W = $clog2(RAMP_SAMPLES);
  localparam int DEN_W  = (17 + LAST_W > 21) ? 17 + LAST_W : 21;
  localparam int PW     = 16 + DEN_W;
  localparam int IW     = (LAST_W > 8) ? LAST_W : 8;
  localparam logic [DEN_W-1:0] LAST = DEN_W'(RAMP_SAMPLES - 1);
  localparam logic [IW-1:0] LAST_I = IW'(RAMP_SAMPLES - 1);
  localparam logic [AW-1:0] MAX_LOADED = AW'(STOP_DEPTH - 2);
  localparam logic signed [gsrs_pkg::OFF_W-1:0] ONE_S = gsrs_pkg::OFF_W'(gsrs_pkg::ONE_Q16);
  localparam logic signed [20:0] ONE_21 = 21'(gsrs_pkg::ONE_Q16);
  localparam logic [gsrs_pkg::NOFF_W-1:0] ONE_N = gsrs_pkg::NOFF_W'(gsrs_pkg::ONE_Q16);

  gsrs_pkg::raw_ent_t  raw_mem  [STOP_DEPTH];
  gsrs_pkg::norm_ent_t norm_mem [STOP_DEPTH];

  logic                raw_we, norm_we;
  logic [AW-1:0]       raw_waddr, raw_raddr, norm_waddr, norm_raddr;
  gsrs_pkg::raw_ent_t  raw_wdata, raw_rd_r;
  gsrs_pkg::norm_ent_t norm_wdata, norm_rd_r;

  gsrs_pkg::state_t    state_r, state_nxt;
  gsrs_pkg::in_t       item_r, item_nxt;
  gsrs_pkg::mix_sel_t  sel_r, sel_nxt;
  gsrs_pkg::out_t      out_item_r, out_item_nxt;
  logic                out_valid_r, out_valid_nxt;
  logic [AW-1:0]       raw_cnt_r, raw_cnt_nxt;
  logic                stale_r, stale_nxt;
  logic [AW-1:0]       ptr_r, ptr_nxt, before_r, before_nxt, after_r, after_nxt;
  logic                after_v_r, after_v_nxt;
  logic [AW-1:0]       m_r, m_nxt, j_r, j_nxt;
  logic                base_r, base_nxt;
  logic signed [19:0]  e0_off_r, e0_off_nxt, e1_off_r, e1_off_nxt;
  logic signed [19:0]  l1_off_r, l1_off_nxt, l2_off_r, l2_off_nxt;
  logic [63:0]         e0_col_r, e0_col_nxt, e1_col_r, e1_col_nxt;
  logic [63:0]         l1_col_r, l1_col_nxt, l2_col_r, l2_col_nxt;
  logic [63:0]         ca_r, ca_nxt, cb_r, cb_nxt, res_r, res_nxt;
  logic [DEN_W-1:0]    num_r, num_nxt, den_r, den_nxt, pos_r, pos_nxt;
  logic [1:0]          ch_r, ch_nxt;
  logic [3:0]          bit_r, bit_nxt;
  logic [PW-1:0]       acc_r, acc_nxt;
  logic [DEN_W-1:0]    rem_r, rem_nxt;
  logic [15:0]         q_r, q_nxt;
  logic                full_r, full_nxt;

  // channel datapath
  logic [15:0]         ch_a, ch_b, ch_d, ch_v;
  logic                ch_up;
  logic [DEN_W:0]      trial;
  logic                trial_ge;
  logic signed [20:0]  sd_den, sd_num;
  logic [IW-1:0]       idx_sat;
  logic [DEN_W-1:0]    seg_den;

  always_ff @(posedge clk) begin
    if (raw_we) begin
      raw_mem[raw_waddr] <= raw_wdata;
    end
    raw_rd_r <= raw_mem[raw_raddr];
  end

  always_ff @(posedge clk) begin
    if (norm_we) begin
      norm_mem[norm_waddr] <= norm_wdata;
    end
    norm_rd_r <= norm_mem[norm_raddr];
  end

  always_comb begin
    ch_a     = ca_r[16*ch_r +: 16];
    ch_b     = cb_r[16*ch_r +: 16];
    ch_up    = (ch_b >= ch_a);
    ch_d     = ch_up ? (ch_b - ch_a) : (ch_a - ch_b);
    ch_v     = ch_up ? (ch_a + q_r) : (ch_a - q_r);
    trial    = {rem_r, acc_r[bit_r]};
    trial_ge = (trial >= {1'b0, den_r});
    idx_sat  = (IW'(item_r.sample_index) > LAST_I) ? LAST_I : IW'(item_r.sample_index);
    seg_den  = DEN_W'($unsigned(e1_off_r - e0_off_r)) * LAST;
  end

  always_comb begin
    state_nxt     = state_r;
    item_nxt      = item_r;
    sel_nxt       = sel_r;
    out_item_nxt  = out_item_r;
    out_valid_nxt = 1'b0;
    raw_cnt_nxt   = raw_cnt_r;
    stale_nxt     = stale_r;
    ptr_nxt       = ptr_r;
    before_nxt    = before_r;
    after_nxt     = after_r;
    after_v_nxt   = after_v_r;
    m_nxt         = m_r;
    j_nxt         = j_r;
    base_nxt      = base_r;
    e0_off_nxt    = e0_off_r;
    e0_col_nxt    = e0_col_r;
    e1_off_nxt    = e1_off_r;
    e1_col_nxt    = e1_col_r;
    l1_off_nxt    = l1_off_r;
    l1_col_nxt    = l1_col_r;
    l2_off_nxt    = l2_off_r;
    l2_col_nxt    = l2_col_r;
    ca_nxt        = ca_r;
    cb_nxt        = cb_r;
    res_nxt       = res_r;
    num_nxt       = num_r;
    den_nxt       = den_r;
    pos_nxt       = pos_r;
    ch_nxt        = ch_r;
    bit_nxt       = bit_r;
    acc_nxt       = acc_r;
    rem_nxt       = rem_r;
    q_nxt         = q_r;
    full_nxt      = full_r;
    sd_den        = '0;
    sd_num        = '0;
    raw_we        = 1'b0;
    raw_waddr     = ptr_r;
    raw_wdata     = raw_rd_r;
    raw_raddr     = ptr_r;
    norm_we       = 1'b0;
    norm_waddr    = '0;
    norm_wdata    = norm_rd_r;
    norm_raddr    = '0;

    unique case (state_r)
      gsrs_pkg::ST_IDLE: begin
        if (start) begin
          item_nxt = in_item;
          res_nxt  = '0;
          full_nxt = 1'b0;
          case (gsrs_pkg::func_t'(in_item.func))
            gsrs_pkg::FN_LOAD: begin
              if (raw_cnt_r >= MAX_LOADED) begin
                full_nxt  = 1'b1;
                state_nxt = gsrs_pkg::ST_FIN;
              end else begin
                ptr_nxt   = raw_cnt_r;
                state_nxt = gsrs_pkg::ST_INS_RD;
              end
            end
            gsrs_pkg::FN_CLEAR: begin
              raw_cnt_nxt = '0;
              stale_nxt   = 1'b1;
              state_nxt   = gsrs_pkg::ST_FIN;
            end
            gsrs_pkg::FN_SAMPLE: begin
              if (!stale_r) begin
                state_nxt = gsrs_pkg::ST_SM_RD0;
              end else if (raw_cnt_r == '0) begin
                state_nxt = gsrs_pkg::ST_RB_Z0;
              end else begin
                ptr_nxt     = '0;
                before_nxt  = '0;
                after_v_nxt = 1'b0;
                state_nxt   = gsrs_pkg::ST_SC_RD;
              end
            end
            default: state_nxt = gsrs_pkg::ST_FIN;
          endcase
        end
      end

      // insertion: shift larger stops up from the end
      gsrs_pkg::ST_INS_RD: begin
        raw_raddr = ptr_r - 1'b1;
        state_nxt = gsrs_pkg::ST_INS_CMP;
      end
      gsrs_pkg::ST_INS_CMP: begin
        raw_we    = 1'b1;
        raw_waddr = ptr_r;
        if (ptr_r != '0 && raw_rd_r.off > item_r.stop_offset) begin
          raw_wdata = raw_rd_r;
          ptr_nxt   = ptr_r - 1'b1;
          state_nxt = gsrs_pkg::ST_INS_RD;
        end else begin
          raw_wdata.off = item_r.stop_offset;
          raw_wdata.col = {item_r.stop_alpha, item_r.stop_blue,
                           item_r.stop_green, item_r.stop_red};
          raw_cnt_nxt   = raw_cnt_r + 1'b1;
          stale_nxt     = 1'b1;
          state_nxt     = gsrs_pkg::ST_FIN;
        end
      end

      // empty table: black to white
      gsrs_pkg::ST_RB_Z0: begin
        norm_we    = 1'b1;
        norm_waddr = '0;
        norm_wdata = '{off: '0, col: {16'hFFFF, 48'h0}};
        state_nxt  = gsrs_pkg::ST_RB_Z1;
      end
      gsrs_pkg::ST_RB_Z1: begin
        norm_we    = 1'b1;
        norm_waddr = AW'(1);
        norm_wdata = '{off: ONE_N, col: '1};
        base_nxt   = 1'b0;
        stale_nxt  = 1'b0;
        state_nxt  = gsrs_pkg::ST_SM_RD0;
      end

      // find the last stop below 0 and the first above 1
      gsrs_pkg::ST_SC_RD: begin
        raw_raddr = ptr_r;
        state_nxt = gsrs_pkg::ST_SC_CHK;
      end
      gsrs_pkg::ST_SC_CHK: begin
        if (raw_rd_r.off < 0) begin
          before_nxt = ptr_r;
        end
        if (raw_rd_r.off > ONE_S) begin
          after_nxt   = ptr_r;
          after_v_nxt = 1'b1;
          state_nxt   = gsrs_pkg::ST_CP_SET;
        end else if (ptr_r == raw_cnt_r - 1'b1) begin
          state_nxt = gsrs_pkg::ST_CP_SET;
        end else begin
          ptr_nxt   = ptr_r + 1'b1;
          state_nxt = gsrs_pkg::ST_SC_RD;
        end
      end
      gsrs_pkg::ST_CP_SET: begin
        m_nxt     = after_v_r ? (after_r - before_r + 1'b1) : (raw_cnt_r - before_r);
        j_nxt     = '0;
        state_nxt = gsrs_pkg::ST_CP_RD;
      end

      // copy the surviving stops to slot 1 onward, slot 0 is kept for a pad
      gsrs_pkg::ST_CP_RD: begin
        raw_raddr = before_r + j_r;
        state_nxt = gsrs_pkg::ST_CP_WR;
      end
      gsrs_pkg::ST_CP_WR: begin
        norm_we    = 1'b1;
        norm_waddr = j_r + 1'b1;
        norm_wdata = '{off: raw_rd_r.off[gsrs_pkg::NOFF_W-1:0], col: raw_rd_r.col};
        if (j_r == '0) begin
          e0_off_nxt = raw_rd_r.off;
          e0_col_nxt = raw_rd_r.col;
        end
        if (j_r == AW'(1)) begin
          e1_off_nxt = raw_rd_r.off;
          e1_col_nxt = raw_rd_r.col;
        end
        l2_off_nxt = l1_off_r;
        l2_col_nxt = l1_col_r;
        l1_off_nxt = raw_rd_r.off;
        l1_col_nxt = raw_rd_r.col;
        if (j_r == m_r - 1'b1) begin
          state_nxt = (m_r == AW'(1)) ? gsrs_pkg::ST_ONE0 : gsrs_pkg::ST_CLIP_HEAD;
        end else begin
          j_nxt     = j_r + 1'b1;
          state_nxt = gsrs_pkg::ST_CP_RD;
        end
      end

      // single stop: flat ramp
      gsrs_pkg::ST_ONE0: begin
        norm_we    = 1'b1;
        norm_waddr = '0;
        norm_wdata = '{off: '0, col: e0_col_r};
        state_nxt  = gsrs_pkg::ST_ONE1;
      end
      gsrs_pkg::ST_ONE1: begin
        norm_we    = 1'b1;
        norm_waddr = AW'(1);
        norm_wdata = '{off: ONE_N, col: e0_col_r};
        base_nxt   = 1'b0;
        stale_nxt  = 1'b0;
        state_nxt  = gsrs_pkg::ST_SM_RD0;
      end

      gsrs_pkg::ST_CLIP_HEAD: begin
        if (e0_off_r < 0) begin
          sd_den    = {e1_off_r[19], e1_off_r} - {e0_off_r[19], e0_off_r};
          sd_num    = 21'sd0 - {e0_off_r[19], e0_off_r};
          ca_nxt    = e0_col_r;
          cb_nxt    = e1_col_r;
          num_nxt   = DEN_W'($unsigned(sd_num));
          den_nxt   = DEN_W'($unsigned(sd_den));
          sel_nxt   = gsrs_pkg::MX_HEAD;
          ch_nxt    = '0;
          state_nxt = gsrs_pkg::ST_MIX_MUL;
        end else begin
          state_nxt = gsrs_pkg::ST_CLIP_TAIL;
        end
      end
      gsrs_pkg::ST_CLIP_TAIL: begin
        if (l1_off_r > ONE_S) begin
          sd_den    = {l1_off_r[19], l1_off_r} - {l2_off_r[19], l2_off_r};
          sd_num    = ONE_21 - {l2_off_r[19], l2_off_r};
          ca_nxt    = l2_col_r;
          cb_nxt    = l1_col_r;
          num_nxt   = DEN_W'($unsigned(sd_num));
          den_nxt   = DEN_W'($unsigned(sd_den));
          sel_nxt   = gsrs_pkg::MX_TAIL;
          ch_nxt    = '0;
          state_nxt = gsrs_pkg::ST_MIX_MUL;
        end else begin
          state_nxt = gsrs_pkg::ST_PAD_HEAD;
        end
      end
      gsrs_pkg::ST_PAD_HEAD: begin
        if (e0_off_r > 0) begin
          norm_we    = 1'b1;
          norm_waddr = '0;
          norm_wdata = '{off: '0, col: e0_col_r};
          base_nxt   = 1'b0;
        end else begin
          base_nxt = 1'b1;
        end
        state_nxt = gsrs_pkg::ST_PAD_TAIL;
      end
      gsrs_pkg::ST_PAD_TAIL: begin
        if (l1_off_r < ONE_S) begin
          norm_we    = 1'b1;
          norm_waddr = m_r + 1'b1;
          norm_wdata = '{off: ONE_N, col: l1_col_r};
        end
        stale_nxt = 1'b0;
        state_nxt = gsrs_pkg::ST_SM_RD0;
      end

      // sample: walk segments until the position is covered
      gsrs_pkg::ST_SM_RD0: begin
        norm_raddr = AW'(base_r);
        ptr_nxt    = '0;
        pos_nxt    = DEN_W'(idx_sat) << 16;
        state_nxt  = gsrs_pkg::ST_SM_LD0;
      end
      gsrs_pkg::ST_SM_LD0: begin
        e0_off_nxt = 20'(norm_rd_r.off);
        e0_col_nxt = norm_rd_r.col;
        state_nxt  = gsrs_pkg::ST_SM_RD;
      end
      gsrs_pkg::ST_SM_RD: begin
        norm_raddr = AW'(base_r) + ptr_r + 1'b1;
        state_nxt  = gsrs_pkg::ST_SM_CMP;
      end
      gsrs_pkg::ST_SM_CMP: begin
        e1_off_nxt = 20'(norm_rd_r.off);
        e1_col_nxt = norm_rd_r.col;
        if (pos_r > DEN_W'(norm_rd_r.off) * LAST) begin
          e0_off_nxt = 20'(norm_rd_r.off);
          e0_col_nxt = norm_rd_r.col;
          ptr_nxt    = ptr_r + 1'b1;
          state_nxt  = gsrs_pkg::ST_SM_RD;
        end else begin
          state_nxt = gsrs_pkg::ST_SM_DEN;
        end
      end
      gsrs_pkg::ST_SM_DEN: begin
        if (seg_den == '0) begin
          res_nxt   = e1_col_r;
          state_nxt = gsrs_pkg::ST_FIN;
        end else begin
          ca_nxt    = e0_col_r;
          cb_nxt    = e1_col_r;
          den_nxt   = seg_den;
          num_nxt   = pos_r - DEN_W'($unsigned(e0_off_r)) * LAST;
          sel_nxt   = gsrs_pkg::MX_SAMPLE;
          ch_nxt    = '0;
          state_nxt = gsrs_pkg::ST_MIX_MUL;
        end
      end

      // shared mix unit: per channel, multiply then restoring divide
      gsrs_pkg::ST_MIX_MUL: begin
        acc_nxt   = PW'(ch_d) * PW'(num_r) + PW'(den_r >> 1);
        state_nxt = gsrs_pkg::ST_MIX_LD;
      end
      gsrs_pkg::ST_MIX_LD: begin
        rem_nxt   = acc_r[PW-1:16];
        bit_nxt   = 4'd15;
        state_nxt = gsrs_pkg::ST_MIX_DIV;
      end
      gsrs_pkg::ST_MIX_DIV: begin
        rem_nxt = trial_ge ? DEN_W'(trial - {1'b0, den_r}) : trial[DEN_W-1:0];
        q_nxt   = {q_r[14:0], trial_ge};
        bit_nxt = bit_r - 1'b1;
        if (bit_r == '0) begin
          state_nxt = gsrs_pkg::ST_MIX_WB;
        end
      end
      gsrs_pkg::ST_MIX_WB: begin
        res_nxt[16*ch_r +: 16] = ch_v;
        ch_nxt = ch_r + 1'b1;
        state_nxt = (ch_r == 2'd3) ? gsrs_pkg::ST_MIX_DONE : gsrs_pkg::ST_MIX_MUL;
      end
      gsrs_pkg::ST_MIX_DONE: begin
        case (sel_r)
          gsrs_pkg::MX_HEAD: begin
            norm_we    = 1'b1;
            norm_waddr = AW'(1);
            norm_wdata = '{off: '0, col: res_r};
            e0_off_nxt = '0;
            e0_col_nxt = res_r;
            if (m_r == AW'(2)) begin
              l2_off_nxt = '0;
              l2_col_nxt = res_r;
            end
            state_nxt = gsrs_pkg::ST_CLIP_TAIL;
          end
          gsrs_pkg::MX_TAIL: begin
            norm_we    = 1'b1;
            norm_waddr = m_r;
            norm_wdata = '{off: ONE_N, col: res_r};
            l1_off_nxt = ONE_S;
            l1_col_nxt = res_r;
            state_nxt  = gsrs_pkg::ST_PAD_HEAD;
          end
          default: state_nxt = gsrs_pkg::ST_FIN;
        endcase
      end

      gsrs_pkg::ST_FIN: begin
        out_valid_nxt             = 1'b1;
        out_item_nxt.out_red      = res_r[15:0];
        out_item_nxt.out_green    = res_r[31:16];
        out_item_nxt.out_blue     = res_r[47:32];
        out_item_nxt.out_alpha    = res_r[63:48];
        out_item_nxt.loaded_count = 8'(raw_cnt_r);
        out_item_nxt.table_full   = full_r;
        state_nxt                 = gsrs_pkg::ST_IDLE;
      end

      default: state_nxt = gsrs_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= gsrs_pkg::ST_IDLE;
      raw_cnt_r   <= '0;
      stale_r     <= 1'b1;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      raw_cnt_r   <= raw_cnt_nxt;
      stale_r     <= stale_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    item_r     <= item_nxt;
    sel_r      <= sel_nxt;
    out_item_r <= out_item_nxt;
    ptr_r      <= ptr_nxt;
    before_r   <= before_nxt;
    after_r    <= after_nxt;
    after_v_r  <= after_v_nxt;
    m_r        <= m_nxt;
    j_r        <= j_nxt;
    base_r     <= base_nxt;
    e0_off_r   <= e0_off_nxt;
    e0_col_r   <= e0_col_nxt;
    e1_off_r   <= e1_off_nxt;
    e1_col_r   <= e1_col_nxt;
    l1_off_r   <= l1_off_nxt;
    l1_col_r   <= l1_col_nxt;
    l2_off_r   <= l2_off_nxt;
    l2_col_r   <= l2_col_nxt;
    ca_r       <= ca_nxt;
    cb_r       <= cb_nxt;
    res_r      <= res_nxt;
    num_r      <= num_nxt;
    den_r      <= den_nxt;
    pos_r      <= pos_nxt;
    ch_r       <= ch_nxt;
    bit_r      <= bit_nxt;
    acc_r      <= acc_nxt;
    rem_r      <= rem_nxt;
    q_r        <= q_nxt;
    full_r     <= full_nxt;
  end

  assign busy      = (state_r != gsrs_pkg::ST_IDLE);
  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

endmodule
